@@ rtl/rbaot_pkg.sv @@
// Shared types and codes for the relay bank auto-off timer.
package rbaot_pkg;

	// Channel count of the bank; only four channels have registers and outputs.
	localparam int CHANNELS   = 4;
	localparam int EFF_CH     = (CHANNELS < 4) ? CHANNELS : 4;
	localparam int CH_IDX_W   = (EFF_CH > 1) ? $clog2(EFF_CH) : 1;

	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_RELAY_COUNT = 3'd0;
	localparam logic [2:0] REG_ACTIVE_LOW  = 3'd1;
	localparam logic [2:0] REG_MAX_ON_CH0  = 3'd2;
	localparam logic [2:0] REG_MAX_ON_CH1  = 3'd3;
	localparam logic [2:0] REG_MAX_ON_CH2  = 3'd4;
	localparam logic [2:0] REG_MAX_ON_CH3  = 3'd5;

	// Command codes
	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_ON       = 3'd1;
	localparam logic [2:0] FN_OFF      = 3'd2;
	localparam logic [2:0] FN_TIMED_ON = 3'd3;
	localparam logic [2:0] FN_STATUS   = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
	localparam logic [1:0] STAT_NOP       = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [3:0]  relay_index;
		logic [15:0] seconds;
		logic [31:0] current_time;
	} cmd_t;

	typedef struct packed {
		logic [3:0] pin_levels;
		logic [3:0] on_mask;
		logic [2:0] expired_count;
		logic [1:0] status;
	} res_t;

endpackage

@@ rtl/relay_bank_auto_off_timer_core.sv @@
// Relay bank auto-off timer: command sequencer, deadline store and register port.
//
// Usage
//  - cmd channel: cmd_valid / cmd_stall / cmd. An item is taken at a rising edge
//    with cmd_valid high and cmd_stall low. cmd_stall is high while an item is
//    being worked on.
//  - res channel: res_valid / res_stall / res. One result item per command item,
//    held steady in an output register until taken.
//  - APB-style register port: relay_count, active_low_mask, max_on_ch0..3 at
//    byte addresses 0, 4, .. 20; pready is always high. Write only while idle.
// Timing
//  - A tick walks the deadline store through one shared 32-bit compare, one
//    channel a cycle, then loads its result in the final step. Other commands
//    add now + span in one adder in the exec step, then load in the final step.
//    The next item is taken the cycle after the result is loaded.
//  - When the receiver stalls, the finished result waits in the output
//    register; one more item may be worked on, and it then waits in the final
//    step until the output register frees.
// Reset clears all registers, switches every relay off and disarms all
// deadlines; no clearing pass is needed.
module relay_bank_auto_off_timer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  rbaot_pkg::cmd_t               cmd,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output rbaot_pkg::res_t               res,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbaot_pkg::ADDR_W-1:0]  paddr,
	input  logic [rbaot_pkg::DATA_W-1:0]  pwdata,
	output logic [rbaot_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_FINISH
	} state_t;

	// config registers
	logic [2:0]  relay_count_q;
	logic [3:0]  active_low_q;
	logic [15:0] max_on_q [4];

	// block state
	state_t                          state_q;
	logic [3:0]                      on_bits_q;
	logic [31:0]                     deadline_q [rbaot_pkg::EFF_CH];
	logic [rbaot_pkg::CH_IDX_W-1:0]  scan_cnt_q;

	// latched item and result fields
	logic [2:0]  func_q;
	logic [3:0]  idx_q;
	logic [15:0] secs_q;
	logic [31:0] now_q;
	logic [2:0]  expired_q;
	logic [1:0]  status_q;

	logic            res_valid_q;
	rbaot_pkg::res_t res_q;

	// ---------------------------------------------------------------
	// Register port
	// ---------------------------------------------------------------
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[rbaot_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_count_q <= '0;
			active_low_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				max_on_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				rbaot_pkg::REG_RELAY_COUNT: relay_count_q <= pwdata[2:0];
				rbaot_pkg::REG_ACTIVE_LOW:  active_low_q  <= pwdata[3:0];
				rbaot_pkg::REG_MAX_ON_CH0:  max_on_q[0]   <= pwdata[15:0];
				rbaot_pkg::REG_MAX_ON_CH1:  max_on_q[1]   <= pwdata[15:0];
				rbaot_pkg::REG_MAX_ON_CH2:  max_on_q[2]   <= pwdata[15:0];
				rbaot_pkg::REG_MAX_ON_CH3:  max_on_q[3]   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			rbaot_pkg::REG_RELAY_COUNT: prdata = {29'd0, relay_count_q};
			rbaot_pkg::REG_ACTIVE_LOW:  prdata = {28'd0, active_low_q};
			rbaot_pkg::REG_MAX_ON_CH0:  prdata = {16'd0, max_on_q[0]};
			rbaot_pkg::REG_MAX_ON_CH1:  prdata = {16'd0, max_on_q[1]};
			rbaot_pkg::REG_MAX_ON_CH2:  prdata = {16'd0, max_on_q[2]};
			rbaot_pkg::REG_MAX_ON_CH3:  prdata = {16'd0, max_on_q[3]};
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Datapath: one deadline read port, one 32-bit compare unit and one 32-bit add unit
	// ---------------------------------------------------------------
	localparam logic [2:0] EFF_CH_N = 3'(rbaot_pkg::EFF_CH);
	localparam logic [rbaot_pkg::CH_IDX_W-1:0] LAST_CH =
		rbaot_pkg::CH_IDX_W'(rbaot_pkg::EFF_CH - 1);
	localparam logic [rbaot_pkg::CH_IDX_W-1:0] CH_STEP = rbaot_pkg::CH_IDX_W'(1);

	logic [2:0]                      in_use;
	logic [rbaot_pkg::CH_IDX_W-1:0]  rd_idx;
	logic [31:0]                     dl_rd;
	logic                            ch_used;
	logic                            expire_hit;
	logic [15:0]                     span;
	logic [31:0]                     new_deadline;
	logic                            cmd_take;
	logic                            res_free;

	// channels in use, clipped to the bank size
	assign in_use = (relay_count_q > EFF_CH_N) ? EFF_CH_N : relay_count_q;

	assign rd_idx = (state_q == ST_SCAN) ? scan_cnt_q : idx_q[rbaot_pkg::CH_IDX_W-1:0];
	assign dl_rd  = deadline_q[rd_idx];

	// scan: armed and due
	assign ch_used    = {{(3 - rbaot_pkg::CH_IDX_W){1'b0}}, scan_cnt_q} < in_use;
	assign expire_hit = ch_used && (dl_rd != '0) && (dl_rd <= now_q);

	// exec: clamp and add (wraps at 32 bits)
	always_comb begin
		span = max_on_q[idx_q[1:0]];
		if (func_q == rbaot_pkg::FN_TIMED_ON && secs_q < span) begin
			span = secs_q;
		end
	end
	assign new_deadline = now_q + {16'd0, span};

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			on_bits_q   <= '0;
			scan_cnt_q  <= '0;
			func_q      <= '0;
			idx_q       <= '0;
			secs_q      <= '0;
			now_q       <= '0;
			expired_q   <= '0;
			status_q    <= rbaot_pkg::STAT_DONE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			for (int c = 0; c < rbaot_pkg::EFF_CH; c++) begin
				deadline_q[c] <= '0;
			end
		end else begin
			// the final step reloads the output register itself
			if (res_valid_q && !res_stall && state_q != ST_FINISH) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						func_q     <= cmd.func;
						idx_q      <= cmd.relay_index;
						secs_q     <= cmd.seconds;
						now_q      <= cmd.current_time;
						expired_q  <= '0;
						status_q   <= rbaot_pkg::STAT_DONE;
						scan_cnt_q <= '0;
						state_q    <= (cmd.func == rbaot_pkg::FN_TICK) ? ST_SCAN : ST_EXEC;
					end
				end
				ST_SCAN: begin
					if (expire_hit) begin
						on_bits_q[scan_cnt_q] <= 1'b0;
						deadline_q[scan_cnt_q] <= '0;
						expired_q <= expired_q + 3'd1;
					end
					if (scan_cnt_q == LAST_CH) begin
						scan_cnt_q <= '0;
						state_q    <= ST_FINISH;
					end else begin
						scan_cnt_q <= scan_cnt_q + CH_STEP;
					end
				end
				ST_EXEC: begin
					case (func_q) inside
						rbaot_pkg::FN_ON, rbaot_pkg::FN_OFF, rbaot_pkg::FN_TIMED_ON: begin
							if (func_q == rbaot_pkg::FN_TIMED_ON && secs_q == '0) begin
								status_q <= rbaot_pkg::STAT_NOP;
							end else if (idx_q >= {1'b0, in_use}) begin
								status_q <= rbaot_pkg::STAT_BAD_INDEX;
							end else if (func_q == rbaot_pkg::FN_OFF) begin
								on_bits_q[idx_q[1:0]] <= 1'b0;
							end else begin
								on_bits_q[idx_q[1:0]] <= 1'b1;
								deadline_q[rd_idx]    <= new_deadline;
							end
						end
						rbaot_pkg::FN_STATUS: status_q <= rbaot_pkg::STAT_DONE;
						default:              status_q <= rbaot_pkg::STAT_NOP;
					endcase
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// waits here while the previous result is still held
					if (res_free) begin
						res_valid_q         <= 1'b1;
						res_q.pin_levels    <= on_bits_q ^ active_low_q;
						res_q.on_mask       <= on_bits_q;
						res_q.expired_count <= expired_q;
						res_q.status        <= status_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_cmd_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd.func != rbaot_pkg::FN_TICK) |=> (state_q == ST_EXEC))
		else $error("non-tick item did not go to exec");

	a_tick_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd.func == rbaot_pkg::FN_TICK) |=> (state_q == ST_SCAN))
		else $error("tick did not start a scan");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.expired_count <= EFF_CH_N))
		else $error("expired count exceeds bank size");

	a_status_nocount: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != rbaot_pkg::STAT_DONE) |-> (res_q.expired_count == '0))
		else $error("failed command reports expiries");

	a_on_bits_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(on_bits_q) |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_EXEC))
		else $error("relay bits changed outside scan or exec");

	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && res_free) |=> (res_valid_q && state_q == ST_IDLE))
		else $error("finished item not loaded into output register");

endmodule
